// File: design/bda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package bda_pkg;

    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_ALIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic dabble;
        logic align;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic bit_last;
        logic digit_last;
    } t_status;

endpackage

// File: design/binary_to_decimal_ascii.sv
// Top level: binary number in, decimal ASCII digits out, most significant digit first.
// The number is converted one bit per cycle by the shift-and-add-3 loop, then aligned to
// drop leading zeros, then emitted one digit per cycle while the receiver does not stall
// the output. NUMBER_BITS above 32 is treated as 32. A new number is accepted only after
// the last digit of the previous one has been emitted.
// Reset clears the controller state and output valid; datapath registers are not reset.
module binary_to_decimal_ascii #(
    parameter int NUMBER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_digit_char,
    output logic        o_last_digit
);
    import bda_pkg::*;

    localparam int VALUE_BITS = (NUMBER_BITS < 32) ? NUMBER_BITS : 32;
    localparam int DIGITS     = ((VALUE_BITS * 1233) >> 12) + 1;

    t_cmd    cmd;
    t_status status;

    bda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    bda_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_number     (i_number),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

// File: design/bda_datapath.sv
// Datapath: shift-and-add-3 BCD conversion, leading-zero alignment and digit output register.
module bda_datapath #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10
) (
    input  logic               i_clk,
    input  logic [31:0]        i_number,
    input  bda_pkg::t_cmd      i_cmd,
    output bda_pkg::t_status   o_status,
    output logic [5:0]         o_digit_char,
    output logic               o_last_digit
);
    import bda_pkg::*;

    localparam int BCD_W = 4 * DIGITS;
    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int IDX_W = $clog2(DIGITS);

    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [CNT_W-1:0]      r_bit_cnt;
    logic [IDX_W-1:0]      r_rem;
    logic [5:0]            r_char;
    logic                  r_last;

    logic [BCD_W-1:0]      adj;
    logic [IDX_W-1:0]      lead;
    logic [IDX_W-1:0]      shamt;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        lead = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                lead = IDX_W'(i);
            end
        end
        shamt = IDX_W'(DIGITS - 1) - lead;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin     <= i_number[VALUE_BITS-1:0];
            r_bcd     <= '0;
            r_bit_cnt <= CNT_W'(VALUE_BITS - 1);
        end else if (i_cmd.dabble) begin
            r_bcd     <= {adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            r_bin     <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt - 1'b1;
        end else if (i_cmd.align) begin
            r_bcd <= r_bcd << {shamt, 2'b00};
            r_rem <= lead;
        end else if (i_cmd.emit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
            r_rem <= r_rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_char <= ASCII_ZERO + {2'b00, r_bcd[BCD_W-1 -: 4]};
            r_last <= (r_rem == '0);
        end
    end

    assign o_status.bit_last   = (r_bit_cnt == '0);
    assign o_status.digit_last = (r_rem == '0);
    assign o_digit_char        = r_char;
    assign o_last_digit        = r_last;

endmodule

// File: design/bda_ctrl.sv
// Controller: sequences load, conversion, alignment and digit output; owns the handshakes.
module bda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  bda_pkg::t_status i_status,
    output bda_pkg::t_cmd    o_cmd
);
    import bda_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_ready     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                o_cmd.dabble = 1'b1;
                if (i_status.bit_last) begin
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                o_cmd.align = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.digit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

// File: verif/binary_to_decimal_ascii_checker.sv
// Checker for the binary to decimal ASCII converter: predicts digit words and compares them.
module binary_to_decimal_ascii_checker
    import bda_pkg::*;
#(
    parameter int NUMBER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_number,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [5:0]  i_digit_char,
    input  logic        i_last_digit,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [5:0] digit_char;
        logic       last_digit;
    } t_digit_word;

    t_digit_word expected_digits[$];

    function automatic logic [63:0] value_mask();
        if (NUMBER_BITS >= 64) begin
            return '1;
        end
        return (64'd1 << NUMBER_BITS) - 64'd1;
    endfunction

    task automatic queue_decimal_digits(input logic [31:0] number);
        logic [63:0] value;
        logic [3:0]  digit_buf [0:19];
        int          count;
        t_digit_word word;
        value = {32'd0, number} & value_mask();
        count = 0;
        do begin
            digit_buf[count] = 4'(value % 64'd10);
            count++;
            value = value / 64'd10;
        end while (value != 64'd0 && count < 20);
        for (int k = count - 1; k >= 0; k--) begin
            word.digit_char = ASCII_ZERO + 6'(digit_buf[k]);
            word.last_digit = (k == 0);
            expected_digits.push_back(word);
        end
    endtask

    always @(posedge i_clk) begin
        t_digit_word want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected digit word: digit_char=%0d last_digit=%0b",
                           i_digit_char, i_last_digit);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_digits.pop_front();
                    if (i_digit_char !== want.digit_char || i_last_digit !== want.last_digit)
                    begin
                        if (i_digit_char !== want.digit_char) begin
                            $error("digit_char: expected %0d, actual %0d",
                                   want.digit_char, i_digit_char);
                        end
                        if (i_last_digit !== want.last_digit) begin
                            $error("last_digit: expected %0b, actual %0b",
                                   want.last_digit, i_last_digit);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                queue_decimal_digits(i_number);
            end
            o_pending <= expected_digits.size();
        end
    end

endmodule

// File: verif/binary_to_decimal_ascii_tb.sv
// Testbench top for the binary to decimal ASCII converter: stimulus, watchdog and verdict.
module binary_to_decimal_ascii_tb;

    localparam int NUMBER_BITS   = 32;
    localparam int RANDOM_COUNT  = 434;
    localparam int QUIET_COUNT   = 50;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int DRAIN_CYCLES  = 60;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [31:0] i_number     = '0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [5:0]  o_digit_char;
    logic        o_last_digit;
    logic        quiet        = 1'b0;
    int          fail_count;
    int          pending;
    int          idle_cycles  = 0;

    binary_to_decimal_ascii #(
        .NUMBER_BITS(NUMBER_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_number     (i_number),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    binary_to_decimal_ascii_checker #(
        .NUMBER_BITS(NUMBER_BITS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_number     (i_number),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_digit_char (o_digit_char),
        .i_last_digit (o_last_digit),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_number(input logic [31:0] number);
        i_valid  <= 1'b1;
        i_number <= number;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_with_gap(input logic [31:0] number);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        send_number(number);
    endtask

    function automatic logic [31:0] random_number();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned pow;
        int              k;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                k   = $urandom_range(1, 10);
                pow = 1;
                for (int j = 1; j < k; j++) pow = pow * 10;
                lo = (k == 1) ? 0 : pow;
                hi = pow * 10 - 1;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                return $urandom_range(32'(hi), 32'(lo));
            end
            2: return $urandom_range(1000, 0);
            default: begin
                k   = $urandom_range(1, 9);
                pow = 1;
                for (int j = 0; j < k; j++) pow = pow * 10;
                return 32'(pow) + 32'($urandom_range(4, 0)) - 32'd2;
            end
        endcase
    endfunction

    // Receiver stalls in random bursts until the quiet tail.
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(0, 19)) @(negedge i_clk);
        end
    end

    initial begin
        logic [31:0] directed [] = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
            32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
            32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000,
            32'd999999999, 32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
            32'd4294967290, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
        };
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[n]) send_with_gap(directed[n]);
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n == RANDOM_COUNT - QUIET_COUNT) quiet = 1'b1;
            send_with_gap(random_number());
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: binary_to_decimal_ascii.f
design/bda_pkg.sv
design/bda_datapath.sv
design/bda_ctrl.sv
design/binary_to_decimal_ascii.sv
verif/binary_to_decimal_ascii_checker.sv
verif/binary_to_decimal_ascii_tb.sv
